// ----- rtl/lap3_pkg.sv -----
// Shared types and constants for the 3x3 Laplacian edge filter.
// No dependencies; compiled first.
package lap3_pkg;

   localparam int PIX_W      = 8;
   localparam int FW_W       = 12;
   localparam int FH_W       = 16;
   localparam int COL_W      = 11;
   localparam int ROW_W      = 16;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 16;

   // Sum and difference widths for the kernel arithmetic
   localparam int SUM_W  = PIX_W + 3;
   localparam int DIFF_W = SUM_W + 2;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

   // Register map
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_WIDTH  = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_FRAME_HEIGHT = CSR_ADDR_W'(1);

   typedef logic [PIX_W-1:0]      pixel_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

endpackage

// ----- rtl/lap3_if.sv -----
// Valid/ready channel interfaces: pixel input, result output, register writes.
// Depends on lap3_pkg.
interface lap3_req_if;
   import lap3_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type pixel;
   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface lap3_rsp_if;
   import lap3_pkg::*;
   logic      valid;
   logic      ready;
   pixel_type edge_res;
   logic      frame_end;
   modport source (output valid, output edge_res, output frame_end, input ready);
   modport sink   (input valid, input edge_res, input frame_end, output ready);
endinterface

interface lap3_csr_if;
   import lap3_pkg::*;
   logic         valid;
   logic         ready;
   csr_addr_type addr;
   csr_data_type wdata;
   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ----- rtl/laplacian_3x3_edge_filter.sv -----
// Top level of the 3x3 Laplacian edge filter: line store, window, kernel, output register.
// Depends on lap3_pkg, lap3_if.sv and lap3_ram.
//
//   channel  dir  payload                         beat when
//   req      in   pixel[7:0]                      req.valid && req.ready
//   rsp      out  edge_res[7:0], frame_end        rsp.valid && rsp.ready
//   csr      in   addr[7:0], wdata[15:0]          csr.valid && csr.ready (always ready)
//
// One pixel per clock sustained while rsp is not stalled; a result passes through
// the registered read of the line store RAM followed by the kernel register.
// Reset (synchronous) clears counters, window, config and valids; the line store
// is not cleared and needs no sweep.
// A stalled rsp freezes the whole two-stage pipe, so req.ready follows
// !rsp.valid || rsp.ready.
module laplacian_3x3_edge_filter #(
   parameter int MAX_WIDTH = 2048
) (
   input logic         clock,
   input logic         reset,
   lap3_req_if.sink    req,
   lap3_rsp_if.source  rsp,
   lap3_csr_if.sink    csr
);
   import lap3_pkg::*;

   localparam int AW  = $clog2(MAX_WIDTH);
   // compare width: wide enough for the 12-bit register and for MAX_WIDTH itself
   localparam int WCW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;

   // ---------------- config registers ----------------
   logic [FW_W-1:0] frame_width_ff;
   logic [FH_W-1:0] frame_height_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr.valid) begin
         if (csr.addr == REG_FRAME_WIDTH) begin
            frame_width_ff <= csr.wdata[FW_W-1:0];
         end else if (csr.addr == REG_FRAME_HEIGHT) begin
            frame_height_ff <= csr.wdata[FH_W-1:0];
         end
      end
   end

   // Clamped geometry: width in 3..MAX_WIDTH, height at least 3
   logic [WCW-1:0]  width_eff;
   logic [FH_W-1:0] height_eff;

   always_comb begin
      width_eff = WCW'(frame_width_ff);
      if (width_eff > WCW'(MAX_WIDTH)) width_eff = WCW'(MAX_WIDTH);
      if (width_eff < WCW'(3))         width_eff = WCW'(3);
      height_eff = (frame_height_ff < FH_W'(3)) ? FH_W'(3) : frame_height_ff;
   end

   // ---------------- stage 1: accept, position, line store read ----------------
   logic advance;
   logic accept;

   // pipe moves whenever the output register is free or being drained
   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;
   assign accept    = req.valid && advance;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             last_col, last_row;

   always_comb begin
      last_col = WCW'({1'b0, col_ff} + (COL_W + 1)'(1)) >= width_eff;
      last_row = ({1'b0, row_ff} + (ROW_W + 1)'(1)) >= {1'b0, height_eff};
      col_in   = col_ff;
      row_in   = row_ff;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + COL_W'(1);
      end
   end

   logic          s1_valid_ff;
   pixel_type     s1_pixel_ff;
   logic [AW-1:0] s1_addr_ff;
   logic          s1_emit_ff;   // pixel completes an interior window
   logic          s1_end_ff;    // last pixel of the frame

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
         if (req.valid) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req.pixel;
         s1_addr_ff  <= AW'(col_ff);
         s1_emit_ff  <= (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
         s1_end_ff   <= last_col && last_row;
      end
   end

   // Line store: one word per column, {row-1, row-2} packed. Read-modify-write
   // of a column address: the read on accept, the write on s1_fire; neighbouring
   // pixels never share an address since the width is at least 3.
   logic [2*PIX_W-1:0] line_rd;
   pixel_type          above2, above1;
   logic               s1_fire;

   assign s1_fire = s1_valid_ff && advance;
   assign above1  = line_rd[2*PIX_W-1:PIX_W];
   assign above2  = line_rd[PIX_W-1:0];

   lap3_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_addr_ff),
      .wr_data ({s1_pixel_ff, above1}),
      .rd_en   (accept),
      .rd_addr (AW'(col_ff)),
      .rd_data (line_rd)
   );

   // ---------------- stage 2: window shift and kernel ----------------
   // Only the two newest window columns are kept; the third comes in fresh.
   pixel_type win_mid_ff [3];
   pixel_type win_new_ff [3];
   pixel_type fresh      [3];

   assign fresh[0] = above2;
   assign fresh[1] = above1;
   assign fresh[2] = s1_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            win_mid_ff[r] <= '0;
            win_new_ff[r] <= '0;
         end
      end else if (s1_fire) begin
         for (int r = 0; r < 3; r++) begin
            win_mid_ff[r] <= win_new_ff[r];
            win_new_ff[r] <= fresh[r];
         end
      end
   end

   // 8*centre - sum of neighbours. With fresh as the right column, win_mid is
   // the left column and win_new the middle one, so the centre is win_new[1].
   logic [SUM_W-1:0]         nb_sum;
   logic [SUM_W-1:0]         centre_x8;
   logic signed [DIFF_W-1:0] diff;
   pixel_type                edge_sat;

   always_comb begin
      nb_sum = SUM_W'(win_mid_ff[0]) + SUM_W'(win_mid_ff[1]) + SUM_W'(win_mid_ff[2])
             + SUM_W'(win_new_ff[0]) + SUM_W'(win_new_ff[2])
             + SUM_W'(fresh[0]) + SUM_W'(fresh[1]) + SUM_W'(fresh[2]);
      centre_x8 = {win_new_ff[1], 3'b000};
      diff = $signed({2'b00, centre_x8}) - $signed({2'b00, nb_sum});
      if (diff[DIFF_W-1]) begin
         edge_sat = '0;
      end else if (diff[DIFF_W-2:PIX_W] != '0) begin
         edge_sat = '1;
      end else begin
         edge_sat = diff[PIX_W-1:0];
      end
   end

   // ---------------- output register ----------------
   logic      rsp_valid_ff;
   pixel_type edge_res_ff;
   logic      frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         edge_res_ff  <= edge_sat;
         frame_end_ff <= s1_end_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.edge_res  = edge_res_ff;
   assign rsp.frame_end = frame_end_ff;

endmodule

// ----- rtl/lap3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lap3_ram #(
   parameter int  WIDTH = 16,
   parameter int  DEPTH = 2048,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- test/lap3_edge_checker.sv -----
// Scoreboard for laplacian_3x3_edge_filter: tracks register writes and the pixel stream,
// predicts every edge result and compares it with what leaves the rsp channel.
// Depends on lap3_pkg and the channel interfaces of lap3_if.sv.
module lap3_edge_checker #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   lap3_req_if         req,
   lap3_rsp_if         rsp,
   lap3_csr_if         csr,
   output int unsigned error_count,
   output int unsigned pending
);
   import lap3_pkg::*;

   typedef struct packed {
      pixel_type edge_res;
      logic      frame_end;
   } edge_beat_type;

   edge_beat_type    queued_edges[$];
   pixel_type        row_mem [2*MAX_WIDTH];   // lower half: row-2, upper half: row-1
   pixel_type        win [3][3];
   logic [COL_W-1:0] col_pos;
   logic [ROW_W-1:0] row_pos;
   logic [FW_W-1:0]  width_reg;
   logic [FH_W-1:0]  height_reg;

   task automatic report_error(input string msg);
      $display("[%0t] edge check: %s", $time, msg);
      error_count++;
   endtask

   // Slide the window by one pixel and queue the result of an interior centre.
   task automatic predict_edge(input pixel_type px);
      int unsigned   w, h, slot;
      pixel_type     up2, up1;
      int            acc;
      logic          row_done, last_row;
      edge_beat_type beat;
      w = (width_reg < 3) ? 3 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg < 3) ? 3 : height_reg;
      slot = col_pos % MAX_WIDTH;
      up2 = row_mem[slot];
      up1 = row_mem[MAX_WIDTH + slot];
      row_done = (col_pos + 1 >= w);
      last_row = (row_pos + 1 >= h);
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = up2;
      win[1][2] = up1;
      win[2][2] = px;
      row_mem[slot] = up1;
      row_mem[MAX_WIDTH + slot] = px;
      if (row_pos >= 2 && col_pos >= 2) begin
         acc = 8 * int'(win[1][1]);
         for (int r = 0; r < 3; r++)
            for (int k = 0; k < 3; k++)
               if (r != 1 || k != 1)
                  acc = acc - int'(win[r][k]);
         if (acc < 0) acc = 0;
         if (acc > 255) acc = 255;
         beat.edge_res = PIX_W'(acc);
         beat.frame_end = row_done && last_row;
         queued_edges.push_back(beat);
      end
      if (row_done) begin
         col_pos = '0;
         row_pos = last_row ? '0 : row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
   endtask

   always @(posedge clock) begin : watch
      edge_beat_type want;
      if (reset) begin
         width_reg = FRAME_WIDTH_RST;
         height_reg = FRAME_HEIGHT_RST;
         col_pos = '0;
         row_pos = '0;
         win = '{default: '0};
         foreach (row_mem[i]) row_mem[i] = '0;
         queued_edges.delete();
      end else begin
         if (req.valid && req.ready)
            predict_edge(req.pixel);
         if (rsp.valid && rsp.ready) begin
            if (queued_edges.size() == 0) begin
               report_error($sformatf("unexpected result edge_res=%0d frame_end=%0b",
                                      rsp.edge_res, rsp.frame_end));
            end else begin
               want = queued_edges.pop_front();
               if (rsp.edge_res !== want.edge_res)
                  report_error($sformatf("edge_res got %0d want %0d",
                                         rsp.edge_res, want.edge_res));
               if (rsp.frame_end !== want.frame_end)
                  report_error($sformatf("frame_end got %0b want %0b",
                                         rsp.frame_end, want.frame_end));
            end
         end
         if (csr.valid && csr.ready) begin
            case (csr.addr)
               REG_FRAME_WIDTH:  width_reg = csr.wdata[FW_W-1:0];
               REG_FRAME_HEIGHT: height_reg = csr.wdata[FH_W-1:0];
               default: ;
            endcase
         end
      end
      pending = queued_edges.size();
   end

endmodule

// ----- test/testbench.sv -----
// Top of the laplacian_3x3_edge_filter testbench: clock, reset, pixel frames, register
// writes and random flow control on both channels; the verdict comes from the checker.
// Depends on lap3_pkg, lap3_if.sv, the filter RTL and lap3_edge_checker.
module testbench;
   import lap3_pkg::*;

   localparam int MAX_W        = 2048;
   localparam int RANDOM_BEATS = 1350;       // random pixels before the run winds down
   localparam int MAX_IDLE     = 13;         // longest gap or stall per beat
   localparam int SETTLE       = 6;          // covers the two-stage pipe plus margin
   localparam int RUN_LIMIT    = 300_000;    // ~2.3k pixels at worst-case gap+stall, x4
   localparam csr_addr_type REG_FIRST_UNMAPPED = CSR_ADDR_W'(2);

   // Content styles for random frames: uniform noise mostly saturates, smooth
   // areas land inside 0..255, binary gives hard edges.
   typedef enum int {PIX_UNIFORM, PIX_SMOOTH, PIX_BINARY} pixel_mix_type;

   logic        clock;
   logic        reset;
   logic        src_idle_on;   // pixel source inserts gaps
   logic        snk_idle_on;   // result sink inserts stalls
   int unsigned stall_left;
   int unsigned error_count;
   int unsigned pending;

   lap3_req_if req_ch ();
   lap3_rsp_if rsp_ch ();
   lap3_csr_if csr_ch ();

   laplacian_3x3_edge_filter #(.MAX_WIDTH(MAX_W)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   lap3_edge_checker #(.MAX_WIDTH(MAX_W)) edge_scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr         (csr_ch),
      .error_count (error_count),
      .pending     (pending)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic int draw_idle(input logic on);
      return on ? $urandom_range(0, MAX_IDLE) : 0;
   endfunction

   // Result sink: after every rsp beat draw how long to hold ready low before
   // taking the next one. Ready is the only thing driven here.
   always @(posedge clock) begin : result_sink
      int gap;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         gap = draw_idle(snk_idle_on);
         if (gap == 0) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b0;
            stall_left <= gap - 1;
         end
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Run watchdog: a hang or a lost result ends here.
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < RUN_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("testbench failed");
      $finish;
   end

   // Pixel count of one frame as the filter clamps the registers.
   function automatic int unsigned frame_size(input csr_data_type w, input csr_data_type h);
      int unsigned cols, rows;
      cols = w[FW_W-1:0];
      if (cols < 3) cols = 3;
      else if (cols > MAX_W) cols = MAX_W;
      rows = (h < 3) ? 3 : h;
      return cols * rows;
   endfunction

   function automatic pixel_type make_pixel(input pixel_mix_type mix, input int base);
      int v;
      case (mix)
         PIX_SMOOTH: begin
            v = base + $urandom_range(0, 40) - 20;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return PIX_W'(v);
         end
         PIX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default:    return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic pick_flow();
      src_idle_on <= ($urandom_range(0, 2) != 0);
      snk_idle_on <= ($urandom_range(0, 2) != 0);
   endtask

   // One pixel beat. Valid stays high across back-to-back beats; in this task it only
   // drops for a drawn gap, so it is never lowered and raised in the same step.
   task automatic push_pixel(input pixel_type px);
      int gap;
      gap = draw_idle(src_idle_on);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.pixel <= px;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
   endtask

   task automatic stream(input int unsigned count, input pixel_mix_type mix);
      int base;
      base = $urandom_range(0, 255);
      repeat (count) push_pixel(make_pixel(mix, base));
   endtask

   // A 3x3 frame: one centre value inside a uniform ring.
   task automatic send_window(input pixel_type centre, input pixel_type ring);
      for (int i = 0; i < 9; i++)
         push_pixel((i == 4) ? centre : ring);
   endtask

   // Register beat; csr valid is left high so writes can go back to back.
   task automatic write_reg(input csr_addr_type addr, input csr_data_type data);
      csr_ch.valid <= 1'b1;
      csr_ch.addr  <= addr;
      csr_ch.wdata <= data;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
   endtask

   // Stop the pixel stream and wait until every predicted result is out, then
   // let the pipe empty of pixels that give no result.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // New frame geometry, written only once the filter is idle. Now and then a
   // write to an unmapped index rides along; it must change nothing.
   task automatic set_frame(input csr_data_type w, input csr_data_type h);
      wait_drained();
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      if ($urandom_range(0, 3) == 0)
         write_reg(csr_addr_type'($urandom_range(int'(REG_FIRST_UNMAPPED),
                                                 (1 << CSR_ADDR_W) - 1)),
                   csr_data_type'($urandom));
      csr_ch.valid <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned   random_beats, frames, count;
      csr_data_type  w, h;
      pixel_mix_type mix;

      reset = 1'b1;
      src_idle_on = 1'b0;
      snk_idle_on = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.pixel = '0;
      csr_ch.valid = 1'b0;
      csr_ch.addr = '0;
      csr_ch.wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed windows on the smallest frame; junk in the unused width bits
      // must be dropped by the register.
      pick_flow();
      set_frame(16'hF003, 16'd3);
      send_window(8'hFF, 8'h00);     // 8*255 saturates high
      send_window(8'h00, 8'hFF);     // strongly negative, clamps to zero
      send_window(8'd200, 8'd180);   // 1600 - 1440 = 160, exact

      // Width and height below the minimum both act as 3.
      pick_flow();
      set_frame(16'd0, 16'd1);
      stream(9, PIX_UNIFORM);

      // Tallest height. After row 0 the frame is shrunk in place: width 5 from
      // row 1, height 0 ends it at row 2.
      pick_flow();
      set_frame(16'd30, 16'hFFFF);
      stream(30, PIX_BINARY);
      wait_drained();
      write_reg(REG_FRAME_WIDTH, 16'd5);
      write_reg(REG_FRAME_HEIGHT, 16'd0);
      csr_ch.valid <= 1'b0;
      stream(2 * 5, PIX_UNIFORM);

      // Width cut mid row: at column 20 of row 3 width drops to 10, so the next
      // pixel closes row 3 and rows 4 and 5 run 10 wide.
      pick_flow();
      set_frame(16'd40, 16'd6);
      stream(3 * 40 + 20, PIX_SMOOTH);
      wait_drained();
      write_reg(REG_FRAME_WIDTH, 16'd10);
      csr_ch.valid <= 1'b0;
      stream(1 + 2 * 10, PIX_SMOOTH);

      // Random geometry, content and flow; whole frames per setting so width
      // never grows in mid frame.
      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         if ($urandom_range(0, 7) == 0) w = $urandom_range(0, 2);
         else w = $urandom_range(3, 24);
         w[15:12] = 4'($urandom);
         h = $urandom_range(0, 10);
         frames = $urandom_range(1, 3);
         mix = pixel_mix_type'($urandom_range(0, 2));
         count = frames * frame_size(w, h);
         pick_flow();
         set_frame(w, h);
         stream(count, mix);
         random_beats += count;
      end

      wait_drained();
      if (error_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
